FILE: rtl/imu_prp_pkg.sv
// Shared types, constants and helpers of the sensor-hub packet report parser.
package imu_prp_pkg;

  localparam int PAYLOAD_CAPACITY = 256;
  localparam logic [14:0] LenLimit = 15'(PAYLOAD_CAPACITY + 4);
  localparam logic [14:0] HdrLen = 15'd4;
  localparam logic [14:0] MinTsPktLen = 15'd9;
  localparam logic [14:0] TsLastPos = 15'd8;
  localparam logic [14:0] MinTail = 15'd4;

  localparam logic [7:0] SensorChan = 8'h03;
  localparam logic [7:0] TsTag = 8'hFB;
  localparam logic [7:0] IdGyro = 8'h02;
  localparam logic [7:0] IdAccel = 8'h04;
  localparam logic [7:0] IdRot = 8'h08;

  localparam logic [3:0] LenGyro = 4'd10;
  localparam logic [3:0] LenRot = 4'd12;

  typedef enum logic [1:0] {
    KIND_GYRO  = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_ROT   = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_CONT  = 3'd2,
    ST_OVER  = 3'd3,
    ST_BAD   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         accuracy;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
    logic signed [15:0] value_w;
    logic [31:0]        base_timestamp;
    logic [7:0]         channel;
    logic [7:0]         sequence_res;
    logic [2:0]         status;
    logic [2:0]         update_mask;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0] n_res;
    res_t       res0;
    res_t       res1;
  } wr_t;

  function automatic logic [3:0] report_len(input logic [7:0] id);
    logic [3:0] len;
    len = 4'd0;
    if (id == IdGyro || id == IdAccel) len = LenGyro;
    else if (id == IdRot) len = LenRot;
    return len;
  endfunction

endpackage

FILE: rtl/imu_prp_parser.sv
// Input register, packet state and per-byte decode of header, timestamp and reports.
module imu_prp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  imu_prp_pkg::in_t   in_i,
  input  logic               room_i,
  output imu_prp_pkg::wr_t   wr_o
);

  imu_prp_pkg::in_t     in_q;
  logic                 in_valid_q;
  logic                 fire, go, start;
  logic [7:0]           b;

  logic [14:0]          pos_q, pos_d, pos_b;
  logic [14:0]          len_q, len_d, len_b;
  logic                 active_q, active_d;
  logic [7:0]           chan_q, chan_d, chan_b;
  logic [7:0]           seq_q, seq_d, seq_b;
  logic                 parse_q, parse_d, parse_b;
  logic [3:0]           roff_q, roff_d, roff_b;
  logic [31:0]          ts_q, ts_d;
  logic [2:0]           upd_q, upd_d, upd_b;
  imu_prp_pkg::status_e err_q, err_d, err_b;
  logic [7:0]           rb_q [12];
  logic [7:0]           rb_d [12];

  logic [14:0]          raw_len, rem;
  logic [3:0]           rl;
  logic [1:0]           ts_idx;
  logic                 short_end, rep_fire, pkt_end;
  imu_prp_pkg::kind_e   rep_kind;
  imu_prp_pkg::res_t    rep_res, end_res;

  assign fire       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;
  assign start      = in_q.packet_start;
  assign b          = in_q.data_byte;
  assign go         = fire && (start || active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      active_q <= 1'b0;
      chan_q   <= '0;
      seq_q    <= '0;
      parse_q  <= 1'b0;
      roff_q   <= '0;
      ts_q     <= '0;
      upd_q    <= '0;
      err_q    <= imu_prp_pkg::ST_OK;
    end else if (go) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      active_q <= active_d;
      chan_q   <= chan_d;
      seq_q    <= seq_d;
      parse_q  <= parse_d;
      roff_q   <= roff_d;
      ts_q     <= ts_d;
      upd_q    <= upd_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      rb_q <= rb_d;
    end
  end

  always_comb begin
    pos_b    = start ? '0 : pos_q;
    len_b    = start ? '0 : len_q;
    chan_b   = start ? '0 : chan_q;
    seq_b    = start ? '0 : seq_q;
    parse_b  = start ? 1'b0 : parse_q;
    roff_b   = start ? '0 : roff_q;
    upd_b    = start ? '0 : upd_q;
    err_b    = start ? imu_prp_pkg::ST_OK : err_q;

    pos_d     = pos_b + 15'd1;
    len_d     = len_b;
    active_d  = 1'b1;
    chan_d    = chan_b;
    seq_d     = seq_b;
    parse_d   = parse_b;
    roff_d    = roff_b;
    ts_d      = ts_q;
    upd_d     = upd_b;
    err_d     = err_b;
    rb_d      = rb_q;
    raw_len   = {b[6:0], len_b[7:0]};
    rem       = len_b - pos_b;
    rl        = '0;
    ts_idx    = pos_b[1:0] - 2'd1;
    short_end = 1'b0;
    rep_fire  = 1'b0;

    if (pos_b == 15'd0) begin
      len_d = {7'd0, b};
    end else if (pos_b == 15'd1) begin
      len_d = raw_len;
      if (raw_len < imu_prp_pkg::HdrLen) begin
        active_d  = 1'b0;
        short_end = 1'b1;
      end else if (b[7]) begin
        err_d = imu_prp_pkg::ST_CONT;
      end else if (raw_len > imu_prp_pkg::LenLimit) begin
        err_d = imu_prp_pkg::ST_OVER;
      end
    end else if (pos_b == 15'd2) begin
      chan_d = b;
    end else if (pos_b == 15'd3) begin
      seq_d = b;
    end else if (pos_b == imu_prp_pkg::HdrLen) begin
      parse_d = (err_b == imu_prp_pkg::ST_OK) && (chan_b == imu_prp_pkg::SensorChan) &&
                (b == imu_prp_pkg::TsTag) && (len_b >= imu_prp_pkg::MinTsPktLen);
    end else if (parse_b) begin
      if (pos_b <= imu_prp_pkg::TsLastPos) begin
        ts_d[{ts_idx, 3'b000} +: 8] = b;
      end else if (roff_b == 4'd0) begin
        if (rem < imu_prp_pkg::MinTail) begin
          parse_d = 1'b0;
        end else begin
          rl = imu_prp_pkg::report_len(b);
          if (rl == 4'd0 || {11'd0, rl} > rem) begin
            err_d   = imu_prp_pkg::ST_BAD;
            parse_d = 1'b0;
          end else begin
            rb_d[0] = b;
            roff_d  = 4'd1;
          end
        end
      end else begin
        rl           = imu_prp_pkg::report_len(rb_q[0]);
        rb_d[roff_b] = b;
        roff_d       = roff_b + 4'd1;
        if (roff_b + 4'd1 >= rl) begin
          rep_fire = 1'b1;
          roff_d   = 4'd0;
        end
      end
    end

    if (rb_d[0] == imu_prp_pkg::IdGyro) rep_kind = imu_prp_pkg::KIND_GYRO;
    else if (rb_d[0] == imu_prp_pkg::IdAccel) rep_kind = imu_prp_pkg::KIND_ACCEL;
    else rep_kind = imu_prp_pkg::KIND_ROT;

    if (rep_fire) begin
      upd_d = upd_b | (3'b001 << rep_kind);
    end

    pkt_end = !short_end && (pos_b >= 15'd3) &&
              (({1'b0, pos_b} + 16'd1) >= {1'b0, len_d});
    if (pkt_end) begin
      active_d = 1'b0;
    end

    rep_res                = '0;
    rep_res.kind           = rep_kind;
    rep_res.accuracy       = rb_d[2][1:0];
    rep_res.value_x        = {rb_d[5], rb_d[4]};
    rep_res.value_y        = {rb_d[7], rb_d[6]};
    rep_res.value_z        = {rb_d[9], rb_d[8]};
    rep_res.value_w        = (rep_kind == imu_prp_pkg::KIND_ROT) ? {rb_d[11], rb_d[10]} : '0;
    rep_res.base_timestamp = ts_d;
    rep_res.channel        = chan_d;
    rep_res.sequence_res   = seq_d;
    rep_res.last           = !pkt_end;

    end_res                = '0;
    end_res.kind           = imu_prp_pkg::KIND_END;
    end_res.base_timestamp = ts_d;
    end_res.channel        = chan_d;
    end_res.sequence_res   = seq_d;
    end_res.status         = short_end ? imu_prp_pkg::ST_SHORT : err_d;
    end_res.update_mask    = (short_end || err_d != imu_prp_pkg::ST_OK) ? 3'b000 : upd_d;
    end_res.last           = 1'b1;

    wr_o = '0;
    if (go) begin
      if (short_end) begin
        wr_o.n_res = 2'd1;
        wr_o.res0  = end_res;
      end else if (rep_fire && pkt_end) begin
        wr_o.n_res = 2'd2;
        wr_o.res0  = rep_res;
        wr_o.res1  = end_res;
      end else if (rep_fire) begin
        wr_o.n_res = 2'd1;
        wr_o.res0  = rep_res;
      end else if (pkt_end) begin
        wr_o.n_res = 2'd1;
        wr_o.res0  = end_res;
      end
    end
  end

endmodule

FILE: rtl/imu_prp_out_fifo.sv
// Four-entry result queue taking up to two results per cycle and giving one.
module imu_prp_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  imu_prp_pkg::wr_t  wr_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output imu_prp_pkg::res_t out_o
);

  imu_prp_pkg::res_t mem_q [4];
  logic [1:0]        wr_ptr_q, rd_ptr_q;
  logic [2:0]        cnt_q;
  logic              pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i) begin
    if (wr_i.n_res != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_i.res0;
    end
    if (wr_i.n_res == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= wr_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + wr_i.n_res;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_q + {1'b0, wr_i.n_res} - {2'b00, pop};
    end
  end

endmodule

FILE: rtl/imu_packet_report_parser_unit.sv
// Top level of the sensor-hub packet report parser.
//
// Input channel: one packet byte per beat (in_i.data_byte), with
// in_i.packet_start high on header byte 0. Bytes outside a packet are dropped.
// Output channel: one result per beat; gyro, linear acceleration and
// rotation vector reports as they complete, and one end-of-packet status
// beat carrying the update mask. A byte yields zero, one or two results;
// out_o.last marks the final result of a byte.
// Each result passes the input register and then the result queue.
// Throughput: one byte per cycle. A byte is taken while the four-entry
// result queue holds at most two results, so a steadily ready receiver
// never slows the input.
// Reset clears the packet state and empties the queue; the block then waits
// for a byte with packet_start. When the receiver stalls, the queue fills
// and in_ready_o drops once three results wait while a byte is held in the
// input register; the held result stays unchanged until taken.
module imu_packet_report_parser_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  imu_prp_pkg::in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output imu_prp_pkg::res_t out_o
);

  imu_prp_pkg::wr_t wr;
  logic             room;

  imu_prp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .room_i     (room),
    .wr_o       (wr)
  );

  imu_prp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

FILE: rtl/imu_prp_checker.sv
// Port-level checks of the packet report parser and their bind to the top level.
module imu_prp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input imu_prp_pkg::in_t  in_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input imu_prp_pkg::res_t out_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("waiting input beat changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_o.last |=>
      out_valid_o && (out_o.kind == imu_prp_pkg::KIND_END))
    else $error("report without last not followed by end status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind == imu_prp_pkg::KIND_END) &&
    (out_o.status != imu_prp_pkg::ST_OK) |-> (out_o.update_mask == 3'b000))
    else $error("update mask set on error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind != imu_prp_pkg::KIND_END) |->
      (out_o.status == imu_prp_pkg::ST_OK) && (out_o.update_mask == 3'b000))
    else $error("report result carries status or mask");

endmodule

bind imu_packet_report_parser_unit imu_prp_checker u_imu_prp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
